// ----- rtl/core/sisd_pkg.sv -----
package sisd_pkg;

   localparam int SRAM_DEPTH_DEF   = 2048;
   localparam int POINTER_BITS_DEF = 13;
   localparam int BYTE_BITS        = 8;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [3:0] PORT_ID      = 4'd0;
   localparam logic [3:0] PORT_SWITCH  = 4'd1;
   localparam logic [3:0] PORT_COLOUR  = 4'd3;
   localparam logic [3:0] PORT_PATTERN = 4'd4;
   localparam logic [3:0] PORT_PTR_LO  = 4'd7;
   localparam logic [3:0] PORT_PTR_HI  = 4'd8;
   localparam logic [3:0] PORT_SRAM    = 4'd9;

   localparam logic [7:0] ID_BYTE        = 8'hF7;
   localparam logic [7:0] SWITCH_ON_BYTE = 8'h7F;
   localparam logic [7:0] IDLE_BYTE      = 8'hFF;
   localparam logic [7:0] WRITE_BYTE     = 8'h00;
   localparam logic [7:0] ERASED_BYTE    = 8'hFF;

   typedef struct packed {
      logic       kind;
      logic [3:0] port;
      logic [7:0] write_data;
      logic       front_switch;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       cpu_fast;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic load_direct;
      logic load_fetched;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic sram_read;
   } sts_type;

endpackage

// ----- rtl/core/sisd_ram.sv -----
module sisd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sisd_ctrl.sv -----
module sisd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_stall,
   input  sisd_pkg::sts_type sts,
   output logic              req_stall,
   output logic              rsp_valid,
   output sisd_pkg::cmd_type cmd
);

   import sisd_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_FETCH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_blocked;
   logic      accept;

   // a result still held and stalled blocks the next word
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE) || out_blocked;
   assign accept      = req_valid && !req_stall;

   always_comb begin
      cmd.clear_en     = (state_ff == ST_CLEAR);
      cmd.accept       = accept;
      cmd.load_direct  = accept && !sts.sram_read;
      cmd.load_fetched = (state_ff == ST_FETCH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && sts.sram_read) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_direct || cmd.load_fetched) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/sisd_dpath.sv -----
module sisd_dpath #(
   parameter int SRAM_DEPTH   = sisd_pkg::SRAM_DEPTH_DEF,
   parameter int POINTER_BITS = sisd_pkg::POINTER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  sisd_pkg::cmd_type cmd,
   input  sisd_pkg::req_type req_data,
   output sisd_pkg::sts_type sts,
   output sisd_pkg::rsp_type rsp_data
);

   import sisd_pkg::*;

   localparam int ADDR_BITS = $clog2(SRAM_DEPTH);
   localparam int HIGH_BITS = POINTER_BITS - BYTE_BITS;
   localparam int CMP_BITS  = 17;
   localparam logic [POINTER_BITS-1:0] PTR_ONE  = POINTER_BITS'(1);
   localparam logic [ADDR_BITS-1:0]    CLR_ONE  = ADDR_BITS'(1);
   localparam logic [ADDR_BITS-1:0]    CLR_LAST = ADDR_BITS'(SRAM_DEPTH - 1);

   logic [POINTER_BITS-1:0] ptr_ff, ptr_in;
   logic [3:0]              col_first_ff, col_first_in;
   logic [3:0]              col_second_ff, col_second_in;
   logic [7:0]              pattern_ff, pattern_in;
   logic                    speed_ff, speed_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic                    fetch_hit_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic                    in_range;
   logic                    is_sram;
   logic [7:0]              direct_data;
   logic [3:0]              nib_hi, nib_lo;
   logic [ADDR_BITS-1:0]    ram_addr;
   logic                    ram_wr_en, ram_rd_en;
   logic [7:0]              ram_wr_data, ram_rd_data;

   assign in_range = CMP_BITS'(ptr_ff) < CMP_BITS'(SRAM_DEPTH);
   assign is_sram  = (req_data.port == PORT_SRAM);

   assign sts.clear_done = (clr_addr_ff == CLR_LAST);
   assign sts.sram_read  = (req_data.kind == KIND_READ) && is_sram;

   assign nib_hi = pattern_ff[7] ? col_second_ff : col_first_ff;
   assign nib_lo = pattern_ff[6] ? col_second_ff : col_first_ff;

   always_comb begin
      ptr_in        = ptr_ff;
      col_first_in  = col_first_ff;
      col_second_in = col_second_ff;
      pattern_in    = pattern_ff;
      speed_in      = speed_ff;
      direct_data   = WRITE_BYTE;
      if (cmd.accept) begin
         if (req_data.kind == KIND_WRITE) begin
            unique case (req_data.port)
               PORT_SWITCH:  speed_in = req_data.write_data[0];
               PORT_COLOUR: begin
                  col_second_in = req_data.write_data[7:4];
                  col_first_in  = req_data.write_data[3:0];
               end
               PORT_PATTERN: pattern_in = req_data.write_data;
               PORT_PTR_LO:  ptr_in = {ptr_ff[POINTER_BITS-1:BYTE_BITS], req_data.write_data};
               PORT_PTR_HI:  ptr_in = {req_data.write_data[HIGH_BITS-1:0],
                                       ptr_ff[BYTE_BITS-1:0]};
               PORT_SRAM:    ptr_in = ptr_ff + PTR_ONE;
               default: ;
            endcase
         end else begin
            unique case (req_data.port)
               PORT_ID:     direct_data = ID_BYTE;
               PORT_SWITCH: direct_data = req_data.front_switch ? SWITCH_ON_BYTE : IDLE_BYTE;
               PORT_COLOUR: begin
                  direct_data = {nib_hi, nib_lo};
                  pattern_in  = {pattern_ff[5:0], pattern_ff[7:6]};
               end
               PORT_SRAM: begin
                  direct_data = IDLE_BYTE;
                  ptr_in      = ptr_ff + PTR_ONE;
               end
               default:     direct_data = IDLE_BYTE;
            endcase
         end
      end
   end

   // sweep the store to the erased value after reset, then serve port 9
   assign clr_addr_in = cmd.clear_en ? clr_addr_ff + CLR_ONE : clr_addr_ff;
   assign ram_addr    = cmd.clear_en ? clr_addr_ff : ADDR_BITS'(ptr_ff);
   assign ram_wr_en   = cmd.clear_en ||
                        (cmd.accept && req_data.kind == KIND_WRITE && is_sram && in_range);
   assign ram_wr_data = cmd.clear_en ? ERASED_BYTE : req_data.write_data;
   assign ram_rd_en   = cmd.accept && sts.sram_read;

   sisd_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (SRAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_in = rsp_ff;
      priority if (cmd.load_direct) begin
         rsp_in.read_data = direct_data;
         rsp_in.cpu_fast  = speed_in;
      end else if (cmd.load_fetched) begin
         rsp_in.read_data = fetch_hit_ff ? ram_rd_data : IDLE_BYTE;
         rsp_in.cpu_fast  = speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         col_first_ff  <= '0;
         col_second_ff <= '0;
         pattern_ff    <= '0;
         speed_ff      <= 1'b0;
         clr_addr_ff   <= '0;
      end else begin
         ptr_ff        <= ptr_in;
         col_first_ff  <= col_first_in;
         col_second_ff <= col_second_in;
         pattern_ff    <= pattern_in;
         speed_ff      <= speed_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         fetch_hit_ff <= in_range;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/switched_io_sram_device_unit.sv -----
// Sixteen-port I/O device: ID byte, front switch and speed bit, two colours
// with a rotating pattern, a pointer register and a byte SRAM behind port 9.
// Request channel (req_valid, req_stall, req_data) carries one bus access per
// word: kind, port, write_data and the front switch level. Response channel
// (rsp_valid, rsp_stall, rsp_data) returns exactly one word per request:
// read_data (0 on writes) and cpu_fast, the speed bit after the access.
// A response sits in an output register and appears the cycle after the
// request is taken; an SRAM read (port 9 read) goes through the registered
// RAM port and then the output register. Throughput is one request per
// cycle, except a port 9 read, which holds the request side while the RAM
// read completes, and a pending stalled response, which also holds it.
// After reset the control and configuration registers clear and the SRAM
// is swept to 0xFF, one byte a cycle, with req_stall high until all
// SRAM_DEPTH bytes (2048 by default) are erased. While rsp_stall holds a
// pending response, the word stays put and req_stall holds off requests.
module switched_io_sram_device_unit #(
   parameter int SRAM_DEPTH   = sisd_pkg::SRAM_DEPTH_DEF,
   parameter int POINTER_BITS = sisd_pkg::POINTER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sisd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sisd_pkg::rsp_type rsp_data
);

   import sisd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sisd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sisd_dpath #(
      .SRAM_DEPTH   (SRAM_DEPTH),
      .POINTER_BITS (POINTER_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> req_stall)
      else $error("request taken during SRAM clearing");

   a_fetch_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load_fetched |-> $past(cmd.accept && sts.sram_read))
      else $error("SRAM result loaded without a preceding port 9 read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.load_direct || cmd.load_fetched))
      else $error("pending response overwritten");
`endif

endmodule
